FILE: rtl/sfa_pkg.sv
package sfa_pkg;

  localparam int DEFAULT_MAX_SEGMENTS = 64;
  localparam int DEFAULT_OFFSET_BITS  = 16;

  // request types
  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_REINIT = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_FIT     = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL = 3'd2;
  localparam logic [2:0] ST_BAD_FREE   = 3'd3;
  localparam logic [2:0] ST_ZERO_SIZE  = 3'd4;

  // fit modes
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // config register indexes
  localparam logic [1:0] REG_FIT_MODE    = 2'd0;
  localparam logic [1:0] REG_POOL_SIZE   = 2'd1;
  localparam logic [1:0] REG_SMALL_LIMIT = 2'd2;

  localparam logic [1:0]  FIT_MODE_RST    = FIT_FIRST;
  localparam logic [15:0] POOL_SIZE_RST   = 16'd65535;
  localparam logic [15:0] SMALL_LIMIT_RST = 16'd10;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] request_size;
    logic [15:0] block_offset;
  } sfa_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] alloc_offset;
    logic        is_allocated;
    logic [6:0]  free_blocks;
    logic [6:0]  used_blocks;
    logic [15:0] free_bytes;
    logic [15:0] largest_free;
    logic [6:0]  small_free_blocks;
  } sfa_rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     scan_load;
    logic     scan_shift;
  } sfa_cell_ctrl_t;

endpackage

FILE: rtl/sfa_cell.sv
module sfa_cell import sfa_pkg::*; #(
  parameter int OffsetBits = DEFAULT_OFFSET_BITS,
  parameter int IdxBits    = 6,
  parameter int CellIdx    = 0
) (
  input  logic                  clk_i,
  input  sfa_cell_ctrl_t        ctrl_i,
  input  logic [IdxBits-1:0]    idx_i,
  input  logic [OffsetBits-1:0] wr_start_i,
  input  logic [OffsetBits-1:0] wr_len_i,
  input  logic                  wr_used_i,
  input  logic [OffsetBits-1:0] ins_start_i,
  input  logic [OffsetBits-1:0] ins_len_i,
  input  logic                  ins_used_i,
  input  logic [OffsetBits-1:0] left_start_i,
  input  logic [OffsetBits-1:0] left_len_i,
  input  logic                  left_used_i,
  input  logic [OffsetBits-1:0] right_start_i,
  input  logic [OffsetBits-1:0] right_len_i,
  input  logic                  right_used_i,
  input  logic [OffsetBits-1:0] scan_start_i,
  input  logic [OffsetBits-1:0] scan_len_i,
  input  logic                  scan_used_i,
  output logic [OffsetBits-1:0] start_o,
  output logic [OffsetBits-1:0] len_o,
  output logic                  used_o,
  output logic [OffsetBits-1:0] scan_start_o,
  output logic [OffsetBits-1:0] scan_len_o,
  output logic                  scan_used_o
);

  localparam logic [IdxBits:0] MyIdx = (IdxBits+1)'(CellIdx);

  logic [OffsetBits-1:0] start_d, start_q, len_d, len_q;
  logic                  used_d, used_q;
  logic [OffsetBits-1:0] sstart_d, sstart_q, slen_d, slen_q;
  logic                  sused_d, sused_q;
  logic                  hit, hit_next, above, at_or_above;

  assign hit         = {1'b0, idx_i} == MyIdx;
  assign hit_next    = ({1'b0, idx_i} + 1'b1) == MyIdx;
  assign above       = MyIdx > {1'b0, idx_i};
  assign at_or_above = MyIdx >= {1'b0, idx_i};

  always_comb begin
    start_d = start_q;
    len_d   = len_q;
    used_d  = used_q;
    case (ctrl_i.op)
      CELL_WRITE: begin
        if (hit) begin
          start_d = wr_start_i;
          len_d   = wr_len_i;
          used_d  = wr_used_i;
        end
      end
      CELL_INSERT: begin
        if (hit) begin
          start_d = wr_start_i;
          len_d   = wr_len_i;
          used_d  = wr_used_i;
        end else if (hit_next) begin
          start_d = ins_start_i;
          len_d   = ins_len_i;
          used_d  = ins_used_i;
        end else if (above) begin
          start_d = left_start_i;
          len_d   = left_len_i;
          used_d  = left_used_i;
        end
      end
      CELL_DELETE: begin
        if (at_or_above) begin
          start_d = right_start_i;
          len_d   = right_len_i;
          used_d  = right_used_i;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sstart_d = sstart_q;
    slen_d   = slen_q;
    sused_d  = sused_q;
    if (ctrl_i.scan_load) begin
      sstart_d = start_q;
      slen_d   = len_q;
      sused_d  = used_q;
    end else if (ctrl_i.scan_shift) begin
      sstart_d = scan_start_i;
      slen_d   = scan_len_i;
      sused_d  = scan_used_i;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    len_q    <= len_d;
    used_q   <= used_d;
    sstart_q <= sstart_d;
    slen_q   <= slen_d;
    sused_q  <= sused_d;
  end

  assign start_o      = start_q;
  assign len_o        = len_q;
  assign used_o       = used_q;
  assign scan_start_o = sstart_q;
  assign scan_len_o   = slen_q;
  assign scan_used_o  = sused_q;

endmodule

FILE: rtl/segment_fit_allocator_core.sv
// Segment-fit allocator: keeps a pool as an address-ordered row of segment
// cells (start, length, used) and serves one request at a time.
// Request channel: in_valid_i / in_ready_o with in_req_i (allocate, free,
// query, reinitialise). Response channel: out_valid_o / out_ready_i with
// out_rsp_o (status, allocation offset, query answer and pool statistics).
// Config: cfg_we_i / cfg_idx_i / cfg_wdata_i write fit mode, pool size and
// small limit; write only while the block is idle.
// Sequence: a request streams the table through the cell row's scan chain,
// applies its change in an apply state, makes up to two delete shifts when
// a free merges, then runs a second scan that gathers statistics; a zero-size
// allocate skips to that scan, and a reinitialise rewrites the pool first.
// One request is in work at a time; in_ready_o is high only while the block
// waits for a request. The response sits in an output register; the next
// request is taken while it waits, and a stalled receiver holds the finished
// result of the following request back until the register empties.
// Reset: an init state writes a single free segment covering the pool.
module segment_fit_allocator_core import sfa_pkg::*; #(
  parameter int MaxSegments = DEFAULT_MAX_SEGMENTS,
  parameter int OffsetBits  = DEFAULT_OFFSET_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sfa_req_t    in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sfa_rsp_t    out_rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int N  = MaxSegments;
  localparam int OB = OffsetBits;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int LW = (OB > 16) ? OB : 16;

  localparam logic [3:0] S_RST_INIT = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_APPLY    = 4'd3;
  localparam logic [3:0] S_DEL      = 4'd4;
  localparam logic [3:0] S_LOAD     = 4'd5;
  localparam logic [3:0] S_STAT     = 4'd6;
  localparam logic [3:0] S_DONE     = 4'd7;
  localparam logic [3:0] S_INIT     = 4'd8;

  // cell row
  logic [N-1:0][OB-1:0] ent_start, ent_len, scn_start, scn_len;
  logic [N-1:0]         ent_used, scn_used;
  sfa_cell_ctrl_t       cell_ctrl;
  logic [IW-1:0]        cell_idx;
  logic [OB-1:0]        wr_start, wr_len, ins_start, ins_len;
  logic                 wr_used;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [OB-1:0] l_start, l_len, r_start, r_len, sr_start, sr_len;
    logic          l_used, r_used, sr_used;
    if (i == 0) begin : g_first
      assign l_start = '0;
      assign l_len   = '0;
      assign l_used  = 1'b0;
    end else begin : g_mid_l
      assign l_start = ent_start[i-1];
      assign l_len   = ent_len[i-1];
      assign l_used  = ent_used[i-1];
    end
    if (i == N - 1) begin : g_last
      assign r_start  = '0;
      assign r_len    = '0;
      assign r_used   = 1'b0;
      assign sr_start = '0;
      assign sr_len   = '0;
      assign sr_used  = 1'b0;
    end else begin : g_mid_r
      assign r_start  = ent_start[i+1];
      assign r_len    = ent_len[i+1];
      assign r_used   = ent_used[i+1];
      assign sr_start = scn_start[i+1];
      assign sr_len   = scn_len[i+1];
      assign sr_used  = scn_used[i+1];
    end
    sfa_cell #(
      .OffsetBits(OB),
      .IdxBits   (IW),
      .CellIdx   (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .idx_i        (cell_idx),
      .wr_start_i   (wr_start),
      .wr_len_i     (wr_len),
      .wr_used_i    (wr_used),
      .ins_start_i  (ins_start),
      .ins_len_i    (ins_len),
      .ins_used_i   (1'b0),
      .left_start_i (l_start),
      .left_len_i   (l_len),
      .left_used_i  (l_used),
      .right_start_i(r_start),
      .right_len_i  (r_len),
      .right_used_i (r_used),
      .scan_start_i (sr_start),
      .scan_len_i   (sr_len),
      .scan_used_i  (sr_used),
      .start_o      (ent_start[i]),
      .len_o        (ent_len[i]),
      .used_o       (ent_used[i]),
      .scan_start_o (scn_start[i]),
      .scan_len_o   (scn_len[i]),
      .scan_used_o  (scn_used[i])
    );
  end

  // config registers
  logic [1:0]  fit_mode_q;
  logic [15:0] pool_size_q, small_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= FIT_MODE_RST;
      pool_size_q   <= POOL_SIZE_RST;
      small_limit_q <= SMALL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIT_MODE:    fit_mode_q    <= cfg_wdata_i[1:0];
        REG_POOL_SIZE:   pool_size_q   <= cfg_wdata_i;
        REG_SMALL_LIMIT: small_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // controller state
  logic [3:0]    state_d, state_q;
  logic [CW-1:0] k_d, k_q, count_d, count_q;
  sfa_req_t      req_d, req_q;
  logic          found_d, found_q;
  logic [IW-1:0] pick_d, pick_q;
  logic [LW-1:0] best_d, best_q;
  logic [OB-1:0] pk_start_d, pk_start_q, pk_len_d, pk_len_q;
  logic [OB-1:0] f_start_d, f_start_q, f_len_d, f_len_q;
  logic          has_prev_d, has_prev_q, p_used_d, p_used_q;
  logic [OB-1:0] p_start_d, p_start_q, p_len_d, p_len_q;
  logic          run_used_d, run_used_q;
  logic [OB-1:0] run_start_d, run_start_q, run_len_d, run_len_q;
  logic          has_next_d, has_next_q, n_used_d, n_used_q;
  logic [OB-1:0] n_len_d, n_len_q;
  logic          ans_d, ans_q;
  logic [2:0]    status_d, status_q;
  logic [15:0]   aoff_d, aoff_q;
  logic [1:0]    del_cnt_d, del_cnt_q;
  logic [IW-1:0] del_idx_d, del_idx_q;
  logic [CW-1:0] nfree_d, nfree_q, nused_d, nused_q, nsmall_d, nsmall_q;
  logic [15:0]   fbytes_d, fbytes_q;
  logic [OB-1:0] largest_d, largest_q;
  logic          out_valid_d, out_valid_q;
  sfa_rsp_t      rsp_d, rsp_q;

  logic [OB-1:0] cur_start, cur_len, off_m, merged;
  logic          cur_used, cur_fits, take, prev_free, next_free;
  logic [LW-1:0] size_w, cur_left;

  assign cur_start = scn_start[0];
  assign cur_len   = scn_len[0];
  assign cur_used  = scn_used[0];
  assign off_m     = OB'(req_q.block_offset);
  assign size_w    = LW'(req_q.request_size);
  assign cur_fits  = !cur_used && (LW'(cur_len) >= size_w);
  assign cur_left  = LW'(cur_len) - size_w;
  assign prev_free = has_prev_q && !p_used_q;
  assign next_free = has_next_q && !n_used_q;
  assign merged    = f_len_q + (next_free ? n_len_q : '0) + (prev_free ? p_len_q : '0);

  always_comb begin
    case (fit_mode_q)
      FIT_BEST:  take = !found_q || (cur_left <= best_q);
      FIT_WORST: take = !found_q || (cur_left >= best_q);
      default:   take = !found_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    count_d     = count_q;
    req_d       = req_q;
    found_d     = found_q;
    pick_d      = pick_q;
    best_d      = best_q;
    pk_start_d  = pk_start_q;
    pk_len_d    = pk_len_q;
    f_start_d   = f_start_q;
    f_len_d     = f_len_q;
    has_prev_d  = has_prev_q;
    p_used_d    = p_used_q;
    p_start_d   = p_start_q;
    p_len_d     = p_len_q;
    run_used_d  = run_used_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    has_next_d  = has_next_q;
    n_used_d    = n_used_q;
    n_len_d     = n_len_q;
    ans_d       = ans_q;
    status_d    = status_q;
    aoff_d      = aoff_q;
    del_cnt_d   = del_cnt_q;
    del_idx_d   = del_idx_q;
    nfree_d     = nfree_q;
    nused_d     = nused_q;
    nsmall_d    = nsmall_q;
    fbytes_d    = fbytes_q;
    largest_d   = largest_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rsp_d       = rsp_q;

    cell_ctrl   = '{op: CELL_HOLD, scan_load: 1'b0, scan_shift: 1'b0};
    cell_idx    = '0;
    wr_start    = '0;
    wr_len      = '0;
    wr_used     = 1'b0;
    ins_start   = '0;
    ins_len     = '0;

    case (state_q)
      S_RST_INIT, S_INIT: begin
        cell_ctrl.op = CELL_WRITE;
        wr_len       = OB'(pool_size_q);
        count_d      = (pool_size_q != '0) ? CW'(1) : '0;
        state_d      = (state_q == S_INIT) ? S_LOAD : S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d               = in_req_i;
          found_d             = 1'b0;
          has_next_d          = 1'b0;
          ans_d               = 1'b0;
          status_d            = ST_OK;
          aoff_d              = '0;
          del_cnt_d           = '0;
          k_d                 = '0;
          cell_ctrl.scan_load = 1'b1;
          if (in_req_i.req_type == REQ_REINIT) begin
            state_d = S_INIT;
          end else if (in_req_i.req_type == REQ_ALLOC && in_req_i.request_size == '0) begin
            status_d = ST_ZERO_SIZE;
            state_d  = S_LOAD;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (k_q == count_q) begin
          state_d = S_APPLY;
        end else begin
          cell_ctrl.scan_shift = 1'b1;
          k_d         = k_q + 1'b1;
          run_start_d = cur_start;
          run_len_d   = cur_len;
          run_used_d  = cur_used;
          case (req_q.req_type)
            REQ_ALLOC: begin
              if (cur_fits && take) begin
                found_d    = 1'b1;
                pick_d     = IW'(k_q);
                best_d     = cur_left;
                pk_start_d = cur_start;
                pk_len_d   = cur_len;
              end
            end
            REQ_FREE: begin
              if (!found_q && cur_used && cur_start == off_m) begin
                found_d    = 1'b1;
                pick_d     = IW'(k_q);
                f_start_d  = cur_start;
                f_len_d    = cur_len;
                has_prev_d = k_q != '0;
                p_start_d  = run_start_q;
                p_len_d    = run_len_q;
                p_used_d   = run_used_q;
              end
              if (found_q && k_q == CW'(pick_q) + 1'b1) begin
                has_next_d = 1'b1;
                n_len_d    = cur_len;
                n_used_d   = cur_used;
              end
            end
            REQ_QUERY: begin
              if (cur_used && {1'b0, off_m} >= {1'b0, cur_start} &&
                  {1'b0, off_m} < ({1'b0, cur_start} + {1'b0, cur_len})) begin
                ans_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_APPLY: begin
        state_d = S_LOAD;
        case (req_q.req_type)
          REQ_ALLOC: begin
            wr_start = pk_start_q;
            wr_len   = OB'(req_q.request_size);
            wr_used  = 1'b1;
            cell_idx = pick_q;
            if (!found_q) begin
              status_d = ST_NO_FIT;
            end else if (LW'(pk_len_q) == size_w) begin
              cell_ctrl.op = CELL_WRITE;
              aoff_d       = 16'(pk_start_q);
            end else if (count_q == CW'(N)) begin
              status_d = ST_TABLE_FULL;
            end else begin
              cell_ctrl.op = CELL_INSERT;
              ins_start    = pk_start_q + OB'(req_q.request_size);
              ins_len      = pk_len_q - OB'(req_q.request_size);
              count_d      = count_q + 1'b1;
              aoff_d       = 16'(pk_start_q);
            end
          end
          REQ_FREE: begin
            if (!found_q) begin
              status_d = ST_BAD_FREE;
            end else begin
              cell_ctrl.op = CELL_WRITE;
              wr_len       = merged;
              if (prev_free) begin
                cell_idx  = pick_q - 1'b1;
                wr_start  = p_start_q;
                del_idx_d = pick_q;
                del_cnt_d = next_free ? 2'd2 : 2'd1;
                state_d   = S_DEL;
              end else begin
                cell_idx  = pick_q;
                wr_start  = f_start_q;
                del_idx_d = pick_q + 1'b1;
                del_cnt_d = next_free ? 2'd1 : 2'd0;
                state_d   = next_free ? S_DEL : S_LOAD;
              end
            end
          end
          default: ;
        endcase
      end
      S_DEL: begin
        cell_ctrl.op = CELL_DELETE;
        cell_idx     = del_idx_q;
        count_d      = count_q - 1'b1;
        del_cnt_d    = del_cnt_q - 1'b1;
        if (del_cnt_q == 2'd1) state_d = S_LOAD;
      end
      S_LOAD: begin
        cell_ctrl.scan_load = 1'b1;
        k_d       = '0;
        nfree_d   = '0;
        nused_d   = '0;
        nsmall_d  = '0;
        fbytes_d  = '0;
        largest_d = '0;
        state_d   = S_STAT;
      end
      S_STAT: begin
        if (k_q == count_q) begin
          state_d = S_DONE;
        end else begin
          cell_ctrl.scan_shift = 1'b1;
          k_d = k_q + 1'b1;
          if (cur_used) begin
            nused_d = nused_q + 1'b1;
          end else begin
            nfree_d  = nfree_q + 1'b1;
            fbytes_d = fbytes_q + 16'(cur_len);
            if (cur_len > largest_q) largest_d = cur_len;
            if (LW'(cur_len) < LW'(small_limit_q)) nsmall_d = nsmall_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          rsp_d.status            = status_q;
          rsp_d.alloc_offset      = aoff_q;
          rsp_d.is_allocated      = ans_q;
          rsp_d.free_blocks       = 7'(nfree_q);
          rsp_d.used_blocks       = 7'(nused_q);
          rsp_d.free_bytes        = fbytes_q;
          rsp_d.largest_free      = 16'(largest_q);
          rsp_d.small_free_blocks = 7'(nsmall_q);
          state_d                 = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RST_INIT;
      count_q     <= '0;
      k_q         <= '0;
      del_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      del_cnt_q   <= del_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    found_q     <= found_d;
    pick_q      <= pick_d;
    best_q      <= best_d;
    pk_start_q  <= pk_start_d;
    pk_len_q    <= pk_len_d;
    f_start_q   <= f_start_d;
    f_len_q     <= f_len_d;
    has_prev_q  <= has_prev_d;
    p_used_q    <= p_used_d;
    p_start_q   <= p_start_d;
    p_len_q     <= p_len_d;
    run_used_q  <= run_used_d;
    run_start_q <= run_start_d;
    run_len_q   <= run_len_d;
    has_next_q  <= has_next_d;
    n_used_q    <= n_used_d;
    n_len_q     <= n_len_d;
    ans_q       <= ans_d;
    status_q    <= status_d;
    aoff_q      <= aoff_d;
    del_idx_q   <= del_idx_d;
    nfree_q     <= nfree_d;
    nused_q     <= nused_d;
    nsmall_q    <= nsmall_d;
    fbytes_q    <= fbytes_d;
    largest_q   <= largest_d;
    rsp_q       <= rsp_d;
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

FILE: rtl/sfa_checker.sv
module sfa_checker import sfa_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input sfa_rsp_t out_rsp_o
);

  // a stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  // one request in work at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_offset_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_OK |-> out_rsp_o.alloc_offset == '0)
    else $error("offset reported on failed request");

  a_query_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.is_allocated |-> out_rsp_o.status == ST_OK)
    else $error("query answer with error status");

endmodule

bind segment_fit_allocator_core sfa_checker u_sfa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_o  (out_rsp_o)
);
